/* rtl/lzot_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lzot_pkg: shared constants and types of the layer z-order table
// sizes of the layer table and codes of the request channel
// ----------------------------------------------------------------------------
package lzot_pkg;

  // number of layers kept by the table
  localparam int NUM_LAYERS = 16;

  // index of a layer or of a stack position
  localparam int LAY_W = $clog2(NUM_LAYERS);
  // visible count, 0 .. NUM_LAYERS
  localparam int VT_W  = $clog2(NUM_LAYERS + 1);
  // signed stack position, -1 .. NUM_LAYERS
  localparam int POS_W = VT_W + 1;
  // signed stored height, -1 .. NUM_LAYERS-1
  localparam int HGT_W = LAY_W + 1;

  // fixed field widths of the channels
  localparam int REQ_W     = 2;
  localparam int ID_W      = 4;
  localparam int HEIGHT_W  = 5;
  localparam int COUNT_W   = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC = 2'd0,
    REQ_SET   = 2'd1,
    REQ_FREE  = 2'd2,
    REQ_QUERY = 2'd3
  } req_t;

endpackage : lzot_pkg
`default_nettype wire

/* rtl/layer_z_order_table_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// layer_z_order_table_top: layer table and stacking order of a compositor
//
// request channel (in_valid / in_stall): one transaction carries req_type,
// layer_id and new_height. allocate takes the lowest free layer and hides it,
// set height clamps the wanted height and moves the layer in the stack,
// free hides the layer and releases it, query only reports it.
// result channel (out_valid / out_stall): exactly one transaction per request
// with status, result_layer, final_height, shown_count and order_changed.
// one request is handled at a time; in_stall is high from acceptance until
// the result transaction has been taken.
// a set height or free that moves a layer shifts k stack entries,
// one entry per cycle through a single copy path.
// allocate scans the used marks one layer a cycle, up to the last layer
// when all layers are used.
// the next request is accepted in the cycle after the result is taken.
// a stalled result simply holds in its output registers.
// reset (rst, synchronous): all layers unused and hidden, no layer shown.
// ----------------------------------------------------------------------------
module layer_z_order_table_top
  import lzot_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  // request channel
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [REQ_W-1:0]           req_type,
  input  wire logic [ID_W-1:0]            layer_id,
  input  wire logic signed [HEIGHT_W-1:0] new_height,
  // result channel
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic                            status,
  output logic [ID_W-1:0]                 result_layer,
  output logic signed [HEIGHT_W-1:0]      final_height,
  output logic [COUNT_W-1:0]              shown_count,
  output logic                            order_changed
);

  // sequencer states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PREP  = 6'b000010,
    ST_ALLOC = 6'b000100,
    ST_SHIFT = 6'b001000,
    ST_FIN   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  localparam logic signed [POS_W-1:0] P_NEG1 = POS_W'(-1);
  localparam logic signed [POS_W-1:0] P_ZERO = POS_W'(0);
  localparam logic signed [POS_W-1:0] P_ONE  = POS_W'(1);
  localparam logic signed [POS_W-1:0] P_NUM  = POS_W'(NUM_LAYERS);
  localparam logic [LAY_W-1:0]        LAST_LAYER = LAY_W'(NUM_LAYERS - 1);

  state_t state;

  // layer table: used marks, heights and the visible count (reset values given)
  logic [NUM_LAYERS-1:0]          used;
  logic signed [HGT_W-1:0]        hgt [NUM_LAYERS];
  logic [VT_W-1:0]                vt;
  // stack order, position 0 at the bottom; only positions below vt are read
  logic [LAY_W-1:0]               stk [NUM_LAYERS];

  // latched request
  req_t                           req_r;
  logic [LAY_W-1:0]               lay_r;
  logic signed [HEIGHT_W-1:0]     want_r;
  logic                           in_range_r;
  logic                           status_r;
  logic                           changed_r;

  // shift sequencer: cursor, limit and direction of the walk
  logic signed [POS_W-1:0]        pos;
  logic signed [POS_W-1:0]        lim;
  logic signed [POS_W-1:0]        h_r;
  logic                           dir_down;
  logic                           do_insert;
  logic                           vt_inc;
  logic                           vt_dec;

  // allocation scan index
  logic [LAY_W-1:0]               idx;

  // ---------------------------------------------------------------------------
  // height clamp and move decision, evaluated in the prep cycle
  // ---------------------------------------------------------------------------
  logic signed [POS_W-1:0] old_p;
  logic signed [POS_W-1:0] vt_s;
  logic signed [POS_W-1:0] top_p;
  logic signed [POS_W-1:0] want_p;
  logic signed [POS_W-1:0] clamp_h;
  logic                    move_en;

  always_comb begin
    old_p  = POS_W'(hgt[lay_r]);
    vt_s   = $signed({1'b0, vt});
    // a shown layer can go at most to the current top, a hidden one just above it
    top_p  = (old_p >= P_ZERO) ? (vt_s - P_ONE) : vt_s;
    want_p = (req_r == REQ_FREE) ? P_NEG1 : POS_W'(want_r);
    clamp_h = (want_p > top_p) ? top_p : want_p;
    if (clamp_h < P_NEG1) begin
      clamp_h = P_NEG1;
    end
    move_en = in_range_r && (clamp_h != old_p) &&
              (((req_r == REQ_SET) && used[lay_r]) ||
               ((req_r == REQ_FREE) && (old_p >= P_ZERO)));
  end

  // ---------------------------------------------------------------------------
  // shared copy path: one stack entry moves per cycle
  // ---------------------------------------------------------------------------
  logic signed [POS_W-1:0] src_p;
  logic                    shift_cont;
  logic                    copy_ok;
  logic [LAY_W-1:0]        mv_lay;

  always_comb begin
    src_p      = dir_down ? (pos - P_ONE) : (pos + P_ONE);
    shift_cont = dir_down ? (pos > lim) : (pos < lim);
    copy_ok    = (src_p >= P_ZERO) && (src_p < P_NUM) &&
                 (pos >= P_ZERO) && (pos < P_NUM);
    mv_lay     = stk[src_p[LAY_W-1:0]];
  end

  assign in_stall  = (state != ST_IDLE);
  assign out_valid = (state == ST_DONE);

  // ---------------------------------------------------------------------------
  // control state and layer table
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      used  <= '0;
      vt    <= '0;
      for (int i = 0; i < NUM_LAYERS; i++) begin
        hgt[i] <= HGT_W'(-1);
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          if (req_r == REQ_ALLOC) begin
            state <= ST_ALLOC;
          end else begin
            if ((req_r == REQ_FREE) && in_range_r) begin
              used[lay_r] <= 1'b0;
            end
            if (move_en) begin
              hgt[lay_r] <= HGT_W'(clamp_h);
              state      <= ST_SHIFT;
            end else begin
              state <= ST_FIN;
            end
          end
        end
        ST_ALLOC: begin
          if (!used[idx]) begin
            used[idx] <= 1'b1;
            hgt[idx]  <= HGT_W'(-1);
            state     <= ST_FIN;
          end else if (idx == LAST_LAYER) begin
            state <= ST_FIN;
          end
        end
        ST_SHIFT: begin
          if (shift_cont) begin
            // the moved layer takes the number of its new position
            if (copy_ok) begin
              hgt[mv_lay] <= HGT_W'(pos);
            end
          end else begin
            if (vt_dec && (vt != '0)) begin
              vt <= vt - VT_W'(1);
            end else if (vt_inc && (vt != VT_W'(NUM_LAYERS))) begin
              vt <= vt + VT_W'(1);
            end
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_stall) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // request registers, stack order and result registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          req_r      <= req_t'(req_type);
          lay_r      <= LAY_W'(layer_id);
          want_r     <= new_height;
          in_range_r <= (int'(layer_id) < NUM_LAYERS);
          status_r   <= 1'b0;
          changed_r  <= 1'b0;
          idx        <= '0;
        end
      end
      ST_PREP: begin
        if ((req_r != REQ_ALLOC) && move_en) begin
          changed_r <= 1'b1;
          h_r       <= clamp_h;
          vt_inc    <= 1'b0;
          vt_dec    <= 1'b0;
          if (clamp_h < old_p) begin
            pos <= old_p;
            if (clamp_h >= P_ZERO) begin
              // move down: entries between new and old place go up one
              dir_down  <= 1'b1;
              lim       <= clamp_h;
              do_insert <= 1'b1;
            end else begin
              // hide: entries above the old place close the gap
              dir_down  <= 1'b0;
              lim       <= vt_s - P_ONE;
              do_insert <= 1'b0;
              vt_dec    <= 1'b1;
            end
          end else begin
            do_insert <= 1'b1;
            if (old_p >= P_ZERO) begin
              // move up: entries between old and new place go down one
              dir_down <= 1'b0;
              pos      <= old_p;
              lim      <= clamp_h;
            end else begin
              // show: entries from the new place to the top go up one
              dir_down <= 1'b1;
              pos      <= vt_s;
              lim      <= clamp_h;
              vt_inc   <= 1'b1;
            end
          end
        end
      end
      ST_ALLOC: begin
        if (!used[idx]) begin
          lay_r <= idx;
        end else if (idx == LAST_LAYER) begin
          // all layers in use
          status_r <= 1'b1;
          lay_r    <= '0;
        end else begin
          idx <= idx + LAY_W'(1);
        end
      end
      ST_SHIFT: begin
        if (shift_cont) begin
          if (copy_ok) begin
            stk[pos[LAY_W-1:0]] <= mv_lay;
          end
          pos <= dir_down ? (pos - P_ONE) : (pos + P_ONE);
        end else if (do_insert) begin
          stk[h_r[LAY_W-1:0]] <= lay_r;
        end
      end
      ST_FIN: begin
        status        <= status_r;
        result_layer  <= ID_W'(lay_r);
        final_height  <= ((req_r != REQ_ALLOC) && in_range_r) ?
                         HEIGHT_W'(hgt[lay_r]) : HEIGHT_W'(-1);
        shown_count   <= COUNT_W'(vt);
        order_changed <= changed_r;
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

endmodule : layer_z_order_table_top
`default_nettype wire
